FILE: src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 16;
    localparam int unsigned AddrW = 4;
    localparam int unsigned DataW = 32;

    localparam logic [CfgW-1:0] DebounceMsRst    = 16'd50;
    localparam logic [CfgW-1:0] DoubleClickMsRst = 16'd300;
    localparam logic [CfgW-1:0] LongPressMsRst   = 16'd600;

    localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd2;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] double_click_ms;
        logic [CfgW-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic             prev_raw;
        logic             stable_level;
        logic [TimeW-1:0] change_time;
        logic [TimeW-1:0] press_time;
        logic [TimeW-1:0] release_time;
        event_t           pending_event;
    } state_t;

endpackage

FILE: src/bcc_if.sv
// ----------------------------------------------------------------------------
// bcc_sample_if / bcc_result_if
// Valid/ready channels for input samples and classifier results.
// ----------------------------------------------------------------------------
interface bcc_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        raw_level;
    logic        mode;

    modport source (output valid, output now_ms, output raw_level, output mode,
                    input ready);
    modport sink   (input valid, input now_ms, input raw_level, input mode,
                    output ready);
endinterface

interface bcc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       stable_out;

    modport source (output valid, output event_code, output stable_out,
                    input ready);
    modport sink   (input valid, input event_code, input stable_out,
                    output ready);
endinterface

FILE: src/bcc_regs.sv
// ----------------------------------------------------------------------------
// bcc_regs
// APB configuration registers: debounce, double-click and long-press times.
// ----------------------------------------------------------------------------
module bcc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::AddrW-1:0]   paddr,
    input  logic [bcc_pkg::DataW-1:0]   pwdata,
    output logic [bcc_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output bcc_pkg::cfg_t               cfg
);
    import bcc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[AddrW-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE:     cfg_next.debounce_ms     = pwdata[CfgW-1:0];
                REG_DOUBLE_CLICK: cfg_next.double_click_ms = pwdata[CfgW-1:0];
                REG_LONG_PRESS:   cfg_next.long_press_ms   = pwdata[CfgW-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE:     prdata = {{(DataW-CfgW){1'b0}}, cfg_reg.debounce_ms};
            REG_DOUBLE_CLICK: prdata = {{(DataW-CfgW){1'b0}}, cfg_reg.double_click_ms};
            REG_LONG_PRESS:   prdata = {{(DataW-CfgW){1'b0}}, cfg_reg.long_press_ms};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= DebounceMsRst;
            cfg_reg.double_click_ms <= DoubleClickMsRst;
            cfg_reg.long_press_ms   <= LongPressMsRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/bcc_step.sv
// ----------------------------------------------------------------------------
// bcc_step
// Next-state logic for one sample: window expiry, debounce, click and
// long-press classification, or read-and-clear of the pending event.
// ----------------------------------------------------------------------------
module bcc_step (
    input  bcc_pkg::state_t              cur,
    input  bcc_pkg::cfg_t                cfg,
    input  logic [bcc_pkg::TimeW-1:0]    now_ms,
    input  logic                         raw_level,
    input  logic                         mode,
    output bcc_pkg::state_t              nxt,
    output bcc_pkg::event_t              event_code
);
    import bcc_pkg::*;

    logic [TimeW-1:0] d_rel;
    logic [TimeW-1:0] d_chg;
    logic [TimeW-1:0] d_prs;
    logic [TimeW-1:0] d_prs_c;
    logic [TimeW-1:0] dbl_win;
    logic [TimeW-1:0] deb_win;
    logic [TimeW-1:0] long_win;
    logic             single_fire;
    logic             deb_take;
    logic             press_ev;
    logic             release_ev;
    logic             short_hold;
    logic             dbl_fire;
    logic             new_win;
    logic             long_fire;
    event_t           pend_a;
    event_t           pend_b;
    logic [TimeW-1:0] rel_a;
    logic [TimeW-1:0] rel_b;
    logic             stable_n;
    logic [TimeW-1:0] press_n;

    assign dbl_win  = {{(TimeW-CfgW){1'b0}}, cfg.double_click_ms};
    assign deb_win  = {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};
    assign long_win = {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms};

    assign d_rel = now_ms - cur.release_time;
    assign d_chg = now_ms - cur.change_time;
    assign d_prs = now_ms - cur.press_time;

    // expire the double-click window
    assign single_fire = (cur.pending_event == EV_NONE) && (cur.release_time != '0)
                         && (d_rel > dbl_win);
    assign pend_a = single_fire ? EV_SINGLE : cur.pending_event;
    assign rel_a  = single_fire ? '0 : cur.release_time;

    // debounce; a raw change resets the stable time to zero
    assign deb_take   = (raw_level == cur.prev_raw) && (d_chg > deb_win)
                        && (raw_level != cur.stable_level);
    assign press_ev   = deb_take && (raw_level == LEVEL_PRESSED);
    assign release_ev = deb_take && (raw_level == LEVEL_RELEASED);
    assign short_hold = d_prs < long_win;
    assign dbl_fire   = release_ev && short_hold && (rel_a != '0) && (d_rel < dbl_win);
    assign new_win    = release_ev && short_hold && !dbl_fire;

    assign pend_b   = dbl_fire ? EV_DOUBLE : pend_a;
    assign rel_b    = dbl_fire ? '0 : (new_win ? now_ms : rel_a);
    assign stable_n = deb_take ? raw_level : cur.stable_level;
    assign press_n  = press_ev ? now_ms : cur.press_time;
    assign d_prs_c  = press_ev ? '0 : d_prs;

    // long press, fired on a held update unless a long press is already pending
    assign long_fire = (stable_n == LEVEL_PRESSED) && (press_n != '0)
                       && (d_prs_c >= long_win) && (pend_b != EV_LONG);

    always_comb
    begin
        nxt        = cur;
        event_code = EV_NONE;
        if (mode == MODE_READ)
        begin
            event_code        = cur.pending_event;
            nxt.pending_event = EV_NONE;
        end
        else
        begin
            nxt.prev_raw      = raw_level;
            nxt.stable_level  = stable_n;
            nxt.change_time   = (raw_level != cur.prev_raw) ? now_ms : cur.change_time;
            nxt.press_time    = press_n;
            nxt.release_time  = long_fire ? '0 : rel_b;
            nxt.pending_event = long_fire ? EV_LONG : pend_b;
        end
    end

endmodule

FILE: src/button_click_classifier_core.sv
// A result beat appears in the cycle after its sample beat is accepted.
// Throughput: one sample per cycle while result.ready is high; the output register lets a new sample in
// while the previous result is being taken.
// Reset: rst_n clears the state to released/no event, loads the timing
// registers with 50, 300 and 600 ms, and empties the output register.
// ----------------------------------------------------------------------------
// button_click_classifier_core
// Debounced button classifier: single click, double click and long press.
// ----------------------------------------------------------------------------
module button_click_classifier_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::AddrW-1:0]   paddr,
    input  logic [bcc_pkg::DataW-1:0]   pwdata,
    output logic [bcc_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    bcc_sample_if.sink                  sample,
    bcc_result_if.source                result
);
    import bcc_pkg::*;

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;
    event_t step_event;
    logic   accept;
    logic   out_valid_reg;
    logic   out_valid_next;
    event_t out_event_reg;
    logic   out_stable_reg;

    bcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcc_step u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .now_ms     (sample.now_ms),
        .raw_level  (sample.raw_level),
        .mode       (sample.mode),
        .nxt        (state_next),
        .event_code (step_event)
    );

    assign sample.ready      = !out_valid_reg || result.ready;
    assign accept            = sample.valid && sample.ready;
    assign result.valid      = out_valid_reg;
    assign result.event_code = out_event_reg;
    assign result.stable_out = out_stable_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_raw      <= LEVEL_RELEASED;
            state_reg.stable_level  <= LEVEL_RELEASED;
            state_reg.change_time   <= '0;
            state_reg.press_time    <= '0;
            state_reg.release_time  <= '0;
            state_reg.pending_event <= EV_NONE;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_event_reg  <= step_event;
            out_stable_reg <= state_next.stable_level;
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("result beat missing after accepted sample");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (sample.mode == MODE_READ) |=> state_reg.pending_event == EV_NONE)
        else $error("pending event not cleared by read");

    a_stable_matches: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.stable_out == state_reg.stable_level)
        else $error("stable_out differs from debounced level");

    a_update_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (sample.mode == MODE_UPDATE) |=> result.event_code == EV_NONE)
        else $error("update beat returned an event");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid
            && $stable(result.event_code) && $stable(result.stable_out))
        else $error("stalled result beat changed");

endmodule
